// File: sv/atnp_pkg.sv
// Shared types and constants for the argument token number parser.
// Character codes, the decoded character class and the queue geometry.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package atnp_pkg;

   // ASCII codes of interest
   localparam logic [7:0] CH_NUL          = 8'd0;
   localparam logic [7:0] CH_TAB          = 8'd9;
   localparam logic [7:0] CH_SPACE        = 8'd32;
   localparam logic [7:0] CH_COMMA        = 8'd44;
   localparam logic [7:0] CH_MINUS        = 8'd45;
   localparam logic [7:0] CH_ZERO         = 8'd48;
   localparam logic [7:0] CH_ONE          = 8'd49;
   localparam logic [7:0] CH_NINE         = 8'd57;
   localparam logic [7:0] CH_UPPER_A      = 8'd65;
   localparam logic [7:0] CH_UPPER_F      = 8'd70;
   localparam logic [7:0] CH_LOWER_B      = 8'd98;
   localparam logic [7:0] CH_LOWER_X      = 8'd120;
   localparam logic [7:0] HEX_LETTER_OFFS = 8'd55;

   // Token position counter saturates here
   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_REST   = 2'd2;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // One decoded character, as carried through the queue
   typedef struct packed {
      logic       is_sep;     // space, comma, tab or NUL
      logic       is_minus;
      logic       is_dec;     // 0-9
      logic       is_hex_ltr; // A-F
      logic       is_bin;     // 0 or 1
      logic       is_zero;
      logic       is_b;
      logic       is_x;
      logic [3:0] digit;      // digit value for decimal, binary or hex
   } char_class_type;

endpackage

`default_nettype wire

// File: sv/atnp_front.sv
// Front end: accepts characters and decodes them into a character class.
// Pushes the decoded class into the queue. Depends on atnp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module atnp_front (
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [7:0]               req_char_in,
   input  wire logic                     queue_full,
   output logic                          push,
   output atnp_pkg::char_class_type      push_data
);

   logic [3:0] hex_val;

   // Stall while the queue has no room
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // Decode the character; the low nibble of the difference is the letter value
   assign hex_val = req_char_in[3:0] - atnp_pkg::HEX_LETTER_OFFS[3:0];

   always_comb begin
      push_data.is_sep     = (req_char_in == atnp_pkg::CH_SPACE) ||
                             (req_char_in == atnp_pkg::CH_COMMA) ||
                             (req_char_in == atnp_pkg::CH_TAB)   ||
                             (req_char_in == atnp_pkg::CH_NUL);
      push_data.is_minus   = (req_char_in == atnp_pkg::CH_MINUS);
      push_data.is_dec     = (req_char_in >= atnp_pkg::CH_ZERO) &&
                             (req_char_in <= atnp_pkg::CH_NINE);
      push_data.is_hex_ltr = (req_char_in >= atnp_pkg::CH_UPPER_A) &&
                             (req_char_in <= atnp_pkg::CH_UPPER_F);
      push_data.is_bin     = (req_char_in == atnp_pkg::CH_ZERO) ||
                             (req_char_in == atnp_pkg::CH_ONE);
      push_data.is_zero    = (req_char_in == atnp_pkg::CH_ZERO);
      push_data.is_b       = (req_char_in == atnp_pkg::CH_LOWER_B);
      push_data.is_x       = (req_char_in == atnp_pkg::CH_LOWER_X);
      if (push_data.is_hex_ltr) begin
         push_data.digit = hex_val;
      end else begin
         push_data.digit = req_char_in[3:0];
      end
   end

endmodule

`default_nettype wire

// File: sv/atnp_queue.sv
// Short queue between front end and back end, one push and one pop a cycle.
// Holds decoded character classes. Depends on atnp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module atnp_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire atnp_pkg::char_class_type push_data,
   output logic                          full,
   input  wire logic                     pop,
   output logic                          not_empty,
   output atnp_pkg::char_class_type      pop_data
);

   atnp_pkg::char_class_type                entry_ff [atnp_pkg::QUEUE_DEPTH];
   logic [atnp_pkg::QUEUE_AW-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [atnp_pkg::QUEUE_AW-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [atnp_pkg::QUEUE_AW:0]             count_ff, count_in;

   localparam logic [atnp_pkg::QUEUE_AW:0] FULL_COUNT =
      (atnp_pkg::QUEUE_AW+1)'(atnp_pkg::QUEUE_DEPTH);
   localparam logic [atnp_pkg::QUEUE_AW-1:0] LAST_PTR =
      atnp_pkg::QUEUE_AW'(atnp_pkg::QUEUE_DEPTH - 1);

   assign full      = (count_ff == FULL_COUNT);
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: sv/atnp_back.sv
// Back end: runs the decimal, binary and hex accumulators over a token and
// emits one result per closed token through an output register. Uses atnp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module atnp_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     entry_valid,
   input  wire atnp_pkg::char_class_type entry,
   output logic                          pop,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [15:0]            rsp_value,
   output logic                          rsp_not_number
);

   // Token state
   logic        in_token_ff, in_token_in;
   logic [1:0]  pos_ff, pos_in;
   logic        first_zero_ff, first_zero_in;
   logic        hex_mode_ff, hex_mode_in;
   logic        neg_ff, neg_in;
   logic [15:0] dec_acc_ff, dec_acc_in;
   logic [15:0] bin_acc_ff, bin_acc_in;
   logic [15:0] hex_acc_ff, hex_acc_in;
   logic        dec_ok_ff, dec_ok_in;
   logic        hex_ok_ff, hex_ok_in;
   logic        bin_ok_ff, bin_ok_in;
   logic        last_b_ff, last_b_in;

   // Output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_value_ff, rsp_value_in;
   logic        rsp_nn_ff, rsp_nn_in;

   // Token state as seen by the current character (fresh at token start)
   logic [1:0]  cur_pos;
   logic        cur_first_zero, cur_hex_mode, cur_neg;
   logic [15:0] cur_dec_acc, cur_bin_acc, cur_hex_acc;
   logic        cur_dec_ok, cur_hex_ok, cur_bin_ok, cur_last_b;

   // Updated token state after taking the character
   logic [1:0]  nxt_pos;
   logic        nxt_first_zero, nxt_hex_mode, nxt_neg;
   logic [15:0] nxt_dec_acc, nxt_bin_acc, nxt_hex_acc;
   logic        nxt_dec_ok, nxt_hex_ok, nxt_bin_ok, nxt_last_b;

   logic        emit;
   logic        out_free;
   logic        res_ok;
   logic [15:0] res_raw;

   assign emit     = entry.is_sep && in_token_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = entry_valid && (!emit || out_free);

   // Select current state, or reset values when a new token opens
   always_comb begin
      if (in_token_ff) begin
         cur_pos        = pos_ff;
         cur_first_zero = first_zero_ff;
         cur_hex_mode   = hex_mode_ff;
         cur_neg        = neg_ff;
         cur_dec_acc    = dec_acc_ff;
         cur_bin_acc    = bin_acc_ff;
         cur_hex_acc    = hex_acc_ff;
         cur_dec_ok     = dec_ok_ff;
         cur_hex_ok     = hex_ok_ff;
         cur_bin_ok     = bin_ok_ff;
         cur_last_b     = last_b_ff;
      end else begin
         cur_pos        = atnp_pkg::POS_FIRST;
         cur_first_zero = 1'b0;
         cur_hex_mode   = 1'b0;
         cur_neg        = 1'b0;
         cur_dec_acc    = '0;
         cur_bin_acc    = '0;
         cur_hex_acc    = '0;
         cur_dec_ok     = 1'b1;
         cur_hex_ok     = 1'b1;
         cur_bin_ok     = 1'b1;
         cur_last_b     = 1'b0;
      end
   end

   // Take one token character on all three paths
   always_comb begin
      nxt_neg        = cur_neg;
      nxt_dec_acc    = cur_dec_acc;
      nxt_dec_ok     = cur_dec_ok;
      nxt_bin_acc    = cur_bin_acc;
      nxt_bin_ok     = cur_bin_ok && !cur_last_b;
      nxt_last_b     = 1'b0;
      nxt_first_zero = cur_first_zero;
      nxt_hex_mode   = cur_hex_mode;
      nxt_hex_acc    = cur_hex_acc;
      nxt_hex_ok     = cur_hex_ok;

      // decimal: acc * 10 + digit, minus only in first place
      if ((cur_pos == atnp_pkg::POS_FIRST) && entry.is_minus) begin
         nxt_neg = 1'b1;
      end else if (entry.is_dec) begin
         nxt_dec_acc = (cur_dec_acc << 3) + (cur_dec_acc << 1) + {12'd0, entry.digit};
      end else begin
         nxt_dec_ok = 1'b0;
      end

      // binary: a b is only valid as the last character
      if (entry.is_bin) begin
         nxt_bin_acc = {cur_bin_acc[14:0], entry.digit[0]};
      end else if (entry.is_b) begin
         nxt_last_b = 1'b1;
      end else begin
         nxt_bin_ok = 1'b0;
      end

      // hex: prefix check on the first two, digits after that
      unique case (cur_pos)
         atnp_pkg::POS_FIRST: begin
            nxt_first_zero = entry.is_zero;
         end
         atnp_pkg::POS_SECOND: begin
            nxt_hex_mode = cur_first_zero && entry.is_x;
         end
         default: begin
            if (entry.is_dec || entry.is_hex_ltr) begin
               nxt_hex_acc = {cur_hex_acc[11:0], entry.digit};
            end else begin
               nxt_hex_ok = 1'b0;
            end
         end
      endcase

      if (cur_pos == atnp_pkg::POS_REST) begin
         nxt_pos = cur_pos;
      end else begin
         nxt_pos = cur_pos + 2'd1;
      end
   end

   // Pick the closing token's result
   always_comb begin
      if (hex_mode_ff) begin
         res_ok  = hex_ok_ff;
         res_raw = hex_acc_ff;
      end else if (last_b_ff) begin
         res_ok  = bin_ok_ff;
         res_raw = bin_acc_ff;
      end else begin
         res_ok  = dec_ok_ff;
         res_raw = neg_ff ? (16'd0 - dec_acc_ff) : dec_acc_ff;
      end
   end

   // Advance token state
   always_comb begin
      in_token_in   = in_token_ff;
      pos_in        = pos_ff;
      first_zero_in = first_zero_ff;
      hex_mode_in   = hex_mode_ff;
      neg_in        = neg_ff;
      dec_acc_in    = dec_acc_ff;
      bin_acc_in    = bin_acc_ff;
      hex_acc_in    = hex_acc_ff;
      dec_ok_in     = dec_ok_ff;
      hex_ok_in     = hex_ok_ff;
      bin_ok_in     = bin_ok_ff;
      last_b_in     = last_b_ff;
      if (pop) begin
         if (!entry.is_sep) begin
            in_token_in   = 1'b1;
            pos_in        = nxt_pos;
            first_zero_in = nxt_first_zero;
            hex_mode_in   = nxt_hex_mode;
            neg_in        = nxt_neg;
            dec_acc_in    = nxt_dec_acc;
            bin_acc_in    = nxt_bin_acc;
            hex_acc_in    = nxt_hex_acc;
            dec_ok_in     = nxt_dec_ok;
            hex_ok_in     = nxt_hex_ok;
            bin_ok_in     = nxt_bin_ok;
            last_b_in     = nxt_last_b;
         end else begin
            in_token_in = 1'b0;
         end
      end
   end

   // Load or hold the output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_nn_in    = rsp_nn_ff;
      if (pop && emit) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = res_ok ? res_raw : 16'd0;
         rsp_nn_in    = !res_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_token_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_token_ff  <= in_token_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      first_zero_ff <= first_zero_in;
      hex_mode_ff   <= hex_mode_in;
      neg_ff        <= neg_in;
      dec_acc_ff    <= dec_acc_in;
      bin_acc_ff    <= bin_acc_in;
      hex_acc_ff    <= hex_acc_in;
      dec_ok_ff     <= dec_ok_in;
      hex_ok_ff     <= hex_ok_in;
      bin_ok_ff     <= bin_ok_in;
      last_b_ff     <= last_b_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_nn_ff     <= rsp_nn_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_not_number = rsp_nn_ff;

endmodule

`default_nettype wire

// File: sv/argument_token_number_parser.sv
// Command-line number parser: takes one character per cycle and, for every
// token closed by a space, comma, tab or NUL, returns one signed 16-bit value
// with a not_number flag. Tokens starting with 0x are uppercase hex, tokens
// ending in b are binary, all others decimal with an optional leading minus;
// sums wrap modulo 2^16 and an invalid token returns 0. A character is
// accepted every cycle while the two-entry queue between the decoding front
// end and the accumulating back end has room; the back end takes one queued
// character per cycle, so sustained rate is one character per cycle. A result
// is loaded into the output register when the back end pops the closing
// separator from the queue, and the back end only stops while that register
// is held by rsp_stall. Depends on atnp_pkg, atnp_front, atnp_queue and atnp_back.
`timescale 1ns / 1ps
`default_nettype none

module argument_token_number_parser (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [7:0]          req_char_in,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic signed [15:0]       rsp_value,
   output logic                     rsp_not_number
);

   atnp_pkg::char_class_type push_data;
   atnp_pkg::char_class_type pop_data;
   logic                     push;
   logic                     pop;
   logic                     queue_full;
   logic                     queue_not_empty;

   // Decode incoming characters
   atnp_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_char_in (req_char_in),
      .queue_full  (queue_full),
      .push        (push),
      .push_data   (push_data)
   );

   // Decouple front and back
   atnp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .pop_data  (pop_data)
   );

   // Accumulate tokens and deliver results
   atnp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .entry_valid    (queue_not_empty),
      .entry          (pop_data),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_value      (rsp_value),
      .rsp_not_number (rsp_not_number)
   );

endmodule

`default_nettype wire
